// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the palette binder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: the consequent holds in the same cycle.
`define DLPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Non-overlapping implication: the consequent holds in the cycle after the antecedent.
`define DLPB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/dlpb_pkg.sv
// ----------------------------------------------------------------------------
// dlpb_pkg
// Types, opcodes, record kinds and controller states of the palette binder.
// ----------------------------------------------------------------------------
package dlpb_pkg;

  // Input request and output record payloads.
  typedef struct packed {
    logic [63:0] cmd_dword;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [63:0] key;
    logic [63:0] palette_hash;
    logic        overflow;
    logic        run_last;
  } out_t;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_LITTLE_ENDIAN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_SEGMENT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOUTH_SEGMENT = 2'd2;
  localparam logic [7:0] EYE_SEGMENT_RST   = 8'h08;
  localparam logic [7:0] MOUTH_SEGMENT_RST = 8'h09;

  // Record kinds.
  localparam logic [1:0] KIND_PAL  = 2'd0;
  localparam logic [1:0] KIND_HASH = 2'd1;
  localparam logic [1:0] KIND_SEG  = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  // Opcodes.
  localparam logic [7:0] OP_TIMG_HASH  = 8'h20;
  localparam logic [7:0] OP_TIMG_PLAIN = 8'hFD;
  localparam logic [7:0] OP_TRI1       = 8'h05;
  localparam logic [7:0] OP_TRI2       = 8'h06;
  localparam logic [7:0] OP_QUAD       = 8'h07;
  localparam logic [7:0] OP_LOAD_PAL   = 8'hF0;
  localparam logic [7:0] OP_END        = 8'hDF;
  localparam logic [7:0] OP_WIDE_31    = 8'h31;
  localparam logic [7:0] OP_WIDE_32    = 8'h32;
  localparam logic [7:0] OP_WIDE_33    = 8'h33;
  localparam logic [7:0] OP_WIDE_35    = 8'h35;
  localparam logic [7:0] OP_WIDE_36    = 8'h36;
  localparam logic [7:0] OP_WIDE_42    = 8'h42;

  // Image formats and sizes.
  localparam logic [2:0] FMT_RGBA = 3'd0;
  localparam logic [2:0] FMT_CI   = 3'd2;
  localparam logic [1:0] SIZ_16B  = 2'd2;

  // Held texture entry: segment flag above a 64-bit key.
  localparam int HELD_W = 65;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAL,
    ST_RD,
    ST_FL,
    ST_END
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_pal;
    logic rd;
    logic load_ent;
    logic load_end;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic job_pal;
    logic job_end;
    logic fl_more;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/display_list_palette_binder_core.sv
// ----------------------------------------------------------------------------
// display_list_palette_binder_core
// Binds colour-index textures of a display list to their confirmed palette.
// ----------------------------------------------------------------------------
// Takes one 64-bit display-list word per request and emits palette, binding
// and end-of-list records in order. After a word is accepted the sequencer
// passes the palette state and the read state and is ready again in idle;
// each held texture emitted at a flush adds a read and a load state, as the
// sequencer reads the held list out of a RAM with a registered read port
// one entry at a time, and the end record on the last word adds the end
// state. A stalled output adds its stall. No clearing pass follows reset.
`include "assert_macros.svh"

module display_list_palette_binder_core #(
  parameter int HELD_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dlpb_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dlpb_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [dlpb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dlpb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  dlpb_pkg::dp_cmd_t    cmd;
  dlpb_pkg::dp_status_t status;
  logic [2:0]           loads;
  logic                 end_rec;

  // Controller.
  dlpb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  dlpb_datapath #(
    .HELD_DEPTH (HELD_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Assertions on the sequencing of requests and records.
  assign loads   = {cmd.load_pal, cmd.load_ent, cmd.load_end};
  assign end_rec = out_valid && out_data.run_last &&
                   (out_data.record_kind == dlpb_pkg::KIND_END);

  `DLPB_ASSERT_NXT(a_one_request, clk, rst_n, cmd.accept, !in_ready)
  `DLPB_ASSERT_IMP(a_one_load, clk, rst_n, 1'b1, $onehot0(loads))
  `DLPB_ASSERT_IMP(a_load_when_free, clk, rst_n, loads != 3'd0, status.out_free)
  `DLPB_ASSERT_NXT(a_end_record, clk, rst_n, cmd.load_end, end_rec)

endmodule

// File: rtl/dlpb_ram.sv
// ----------------------------------------------------------------------------
// dlpb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dlpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/dlpb_ctrl.sv
// ----------------------------------------------------------------------------
// dlpb_ctrl
// Sequencer that accepts one request and then walks out its records.
// ----------------------------------------------------------------------------
module dlpb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dlpb_pkg::dp_status_t   status,
  output dlpb_pkg::dp_cmd_t      cmd
);

  dlpb_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dlpb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      dlpb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = dlpb_pkg::ST_PAL;
        end
      end
      dlpb_pkg::ST_PAL: begin
        if (!status.job_pal) begin
          state_nxt = dlpb_pkg::ST_RD;
        end else if (status.out_free) begin
          cmd.load_pal = 1'b1;
          state_nxt    = dlpb_pkg::ST_RD;
        end
      end
      dlpb_pkg::ST_RD: begin
        if (status.fl_more) begin
          cmd.rd    = 1'b1;
          state_nxt = dlpb_pkg::ST_FL;
        end else if (status.job_end) begin
          state_nxt = dlpb_pkg::ST_END;
        end else begin
          state_nxt = dlpb_pkg::ST_IDLE;
        end
      end
      dlpb_pkg::ST_FL: begin
        if (status.out_free) begin
          cmd.load_ent = 1'b1;
          state_nxt    = dlpb_pkg::ST_RD;
        end
      end
      dlpb_pkg::ST_END: begin
        if (status.out_free) begin
          cmd.load_end = 1'b1;
          state_nxt    = dlpb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dlpb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/dlpb_datapath.sv
// ----------------------------------------------------------------------------
// dlpb_datapath
// Command decode, palette and held-list state, held texture RAM and the
// output record register.
// ----------------------------------------------------------------------------
module dlpb_datapath #(
  parameter int HELD_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dlpb_pkg::in_t                       in_data,
  input  logic                                cfg_we,
  input  logic [dlpb_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [dlpb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  dlpb_pkg::dp_cmd_t                   cmd,
  output dlpb_pkg::dp_status_t                status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output dlpb_pkg::out_t                      out_data
);

  localparam int AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int CW = $clog2(HELD_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(HELD_DEPTH);

  // Configuration registers.
  logic       little_endian_r;
  logic [7:0] eye_segment_r;
  logic [7:0] mouth_segment_r;

  // List state.
  logic          await_r,    await_nxt;
  logic [5:0]    fmt_bits_r, fmt_bits_nxt;
  logic          staged_v_r, staged_v_nxt;
  logic [63:0]   staged_h_r, staged_h_nxt;
  logic          active_v_r, active_v_nxt;
  logic [63:0]   active_h_r, active_h_nxt;
  logic [CW-1:0] held_cnt_r, held_cnt_nxt;
  logic          ovf_r,      ovf_nxt;
  logic          fin_r,      fin_nxt;

  // Job registers describing the records owed for the current request.
  logic          job_pal_r,  job_pal_nxt;
  logic [CW-1:0] job_n_r,    job_n_nxt;
  logic          job_end_r;
  logic          job_ovf_r;
  logic [63:0]   job_hash_r;
  logic [CW-1:0] fl_idx_r;
  logic [CW-1:0] fl_idx_inc;

  // Output register.
  logic           out_valid_r;
  dlpb_pkg::out_t out_data_r;
  logic           out_free;

  // Decode signals.
  logic [63:0]   c;
  logic [63:0]   word;
  logic [7:0]    op;
  logic [2:0]    fmt;
  logic [1:0]    siz;
  logic [7:0]    seg;
  logic          is_wide;
  logic          is_draw;
  logic          hold_req;
  logic          hold_seg;
  logic [63:0]   hold_key;
  logic          held_wr;
  logic [CW-1:0] cnt_mid;
  logic          flush_req;

  // Held texture RAM.
  logic [dlpb_pkg::HELD_W-1:0] ram_rdata;

  dlpb_ram #(
    .WIDTH (dlpb_pkg::HELD_W),
    .DEPTH (HELD_DEPTH)
  ) u_held_ram (
    .clk   (clk),
    .we    (cmd.accept && held_wr),
    .waddr (held_cnt_r[AW-1:0]),
    .wdata ({hold_seg, hold_key}),
    .re    (cmd.rd),
    .raddr (fl_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Byte order of each 32-bit half and field extraction.
  assign c    = in_data.cmd_dword;
  assign word = little_endian_r ?
                {c[39:32], c[47:40], c[55:48], c[63:56],
                 c[7:0],   c[15:8],  c[23:16], c[31:24]} : c;
  assign op   = word[63:56];
  assign fmt  = word[55:53];
  assign siz  = word[52:51];
  assign seg  = word[31:24];

  assign is_wide = (op == dlpb_pkg::OP_TIMG_HASH) || (op == dlpb_pkg::OP_WIDE_31) ||
                   (op == dlpb_pkg::OP_WIDE_32)   || (op == dlpb_pkg::OP_WIDE_33) ||
                   (op == dlpb_pkg::OP_WIDE_35)   || (op == dlpb_pkg::OP_WIDE_36) ||
                   (op == dlpb_pkg::OP_WIDE_42);
  assign is_draw = (op == dlpb_pkg::OP_TRI1) || (op == dlpb_pkg::OP_TRI2) ||
                   (op == dlpb_pkg::OP_QUAD);

  // Next list state and the job for one request.
  always_comb begin
    await_nxt    = await_r;
    fmt_bits_nxt = fmt_bits_r;
    staged_v_nxt = staged_v_r;
    staged_h_nxt = staged_h_r;
    active_v_nxt = active_v_r;
    active_h_nxt = active_h_r;
    ovf_nxt      = ovf_r;
    fin_nxt      = fin_r;
    hold_req     = 1'b0;
    hold_seg     = 1'b0;
    hold_key     = '0;
    job_pal_nxt  = 1'b0;
    flush_req    = 1'b0;
    held_wr      = 1'b0;
    cnt_mid      = held_cnt_r;

    if (!fin_r) begin
      if (await_r) begin
        // Second word of a wide command: the texture hash.
        await_nxt = 1'b0;
        if (fmt_bits_r[5]) begin
          if (fmt_bits_r[2:0] == dlpb_pkg::FMT_RGBA && fmt_bits_r[4:3] == dlpb_pkg::SIZ_16B)
          begin
            staged_v_nxt = 1'b1;
            staged_h_nxt = word;
          end else if (fmt_bits_r[2:0] == dlpb_pkg::FMT_CI) begin
            hold_req = 1'b1;
            hold_key = word;
          end
        end
      end else if (is_wide) begin
        await_nxt    = 1'b1;
        fmt_bits_nxt = (op == dlpb_pkg::OP_TIMG_HASH) ? {1'b1, siz, fmt} : 6'd0;
      end else if (op == dlpb_pkg::OP_TIMG_PLAIN) begin
        if (fmt == dlpb_pkg::FMT_CI && (seg == eye_segment_r || seg == mouth_segment_r)) begin
          hold_req = 1'b1;
          hold_seg = 1'b1;
          hold_key = {32'd0, seg, 24'd0};
        end
      end else if (op == dlpb_pkg::OP_LOAD_PAL) begin
        if (staged_v_r) begin
          active_v_nxt = 1'b1;
          active_h_nxt = staged_h_r;
          staged_v_nxt = 1'b0;
          job_pal_nxt  = 1'b1;
        end
      end else if (is_draw) begin
        flush_req = 1'b1;
      end else if (op == dlpb_pkg::OP_END) begin
        flush_req = 1'b1;
        fin_nxt   = 1'b1;
      end
    end

    // Append to the held list, or mark overflow when it is full.
    if (hold_req) begin
      if (held_cnt_r >= DEPTH_C) begin
        ovf_nxt = 1'b1;
      end else begin
        held_wr = 1'b1;
        cnt_mid = held_cnt_r + 1'b1;
      end
    end

    if (in_data.last) begin
      flush_req = 1'b1;
    end

    // Entries are only emitted at a flush, and only when a palette has been
    // confirmed.
    job_n_nxt    = (flush_req && active_v_nxt) ? cnt_mid : '0;
    held_cnt_nxt = flush_req ? '0 : cnt_mid;
  end

  // List state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r    <= 1'b0;
      fmt_bits_r <= '0;
      staged_v_r <= 1'b0;
      staged_h_r <= '0;
      active_v_r <= 1'b0;
      active_h_r <= '0;
      held_cnt_r <= '0;
      ovf_r      <= 1'b0;
      fin_r      <= 1'b0;
    end else if (cmd.accept) begin
      if (in_data.last) begin
        // The last word closes the list and returns it to its initial state.
        await_r    <= 1'b0;
        fmt_bits_r <= '0;
        staged_v_r <= 1'b0;
        staged_h_r <= '0;
        active_v_r <= 1'b0;
        active_h_r <= '0;
        held_cnt_r <= '0;
        ovf_r      <= 1'b0;
        fin_r      <= 1'b0;
      end else begin
        await_r    <= await_nxt;
        fmt_bits_r <= fmt_bits_nxt;
        staged_v_r <= staged_v_nxt;
        staged_h_r <= staged_h_nxt;
        active_v_r <= active_v_nxt;
        active_h_r <= active_h_nxt;
        held_cnt_r <= held_cnt_nxt;
        ovf_r      <= ovf_nxt;
        fin_r      <= fin_nxt;
      end
    end
  end

  // Job registers and the flush index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_pal_r <= 1'b0;
      job_n_r   <= '0;
      job_end_r <= 1'b0;
      fl_idx_r  <= '0;
    end else if (cmd.accept) begin
      job_pal_r <= job_pal_nxt;
      job_n_r   <= job_n_nxt;
      job_end_r <= in_data.last;
      fl_idx_r  <= '0;
    end else if (cmd.load_ent) begin
      fl_idx_r  <= fl_idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      job_ovf_r  <= ovf_nxt;
      job_hash_r <= active_h_nxt;
    end
  end

  assign fl_idx_inc = fl_idx_r + 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      little_endian_r <= 1'b0;
      eye_segment_r   <= dlpb_pkg::EYE_SEGMENT_RST;
      mouth_segment_r <= dlpb_pkg::MOUTH_SEGMENT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        dlpb_pkg::CFG_LITTLE_ENDIAN: little_endian_r <= cfg_wdata[0];
        dlpb_pkg::CFG_EYE_SEGMENT:   eye_segment_r   <= cfg_wdata;
        dlpb_pkg::CFG_MOUTH_SEGMENT: mouth_segment_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Output record register.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_pal || cmd.load_ent || cmd.load_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pal) begin
      out_data_r.record_kind  <= dlpb_pkg::KIND_PAL;
      out_data_r.key          <= job_hash_r;
      out_data_r.palette_hash <= job_hash_r;
      out_data_r.overflow     <= job_ovf_r;
      out_data_r.run_last     <= (job_n_r == '0) && !job_end_r;
    end else if (cmd.load_ent) begin
      out_data_r.record_kind  <= ram_rdata[dlpb_pkg::HELD_W-1] ? dlpb_pkg::KIND_SEG
                                                                : dlpb_pkg::KIND_HASH;
      out_data_r.key          <= ram_rdata[63:0];
      out_data_r.palette_hash <= job_hash_r;
      out_data_r.overflow     <= job_ovf_r;
      out_data_r.run_last     <= (fl_idx_inc == job_n_r) && !job_end_r;
    end else if (cmd.load_end) begin
      out_data_r.record_kind  <= dlpb_pkg::KIND_END;
      out_data_r.key          <= '0;
      out_data_r.palette_hash <= '0;
      out_data_r.overflow     <= job_ovf_r;
      out_data_r.run_last     <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status towards the controller.
  assign status.job_pal  = job_pal_r;
  assign status.job_end  = job_end_r;
  assign status.fl_more  = fl_idx_r < job_n_r;
  assign status.out_free = out_free;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the display-list palette binder.
// ----------------------------------------------------------------------------
// Feeds display lists through the request channel under several byte orders
// and segment settings. A scoreboard predicts every palette, binding and end
// record from the accepted requests and checks the record stream field by
// field. Both channels idle at random.
module tb;
  import dlpb_pkg::*;

  localparam int HELD_DEPTH = 16;
  // Longest tail of work after the last record: a full flush plus margin.
  localparam int DRAIN_CYCLES = 64;

  // Predicts the record stream of the binder and checks what comes out.
  class binding_scoreboard;
    // Copies of the registers.
    bit          little_endian;
    logic [7:0]  eye_seg;
    logic [7:0]  mouth_seg;
    // Per-list state.
    bit          await_hash;
    logic [5:0]  img_bits;
    bit          staged_ok;
    logic [63:0] staged_pal;
    bit          active_ok;
    logic [63:0] active_pal;
    bit          held_seg [HELD_DEPTH];
    logic [63:0] held_key [HELD_DEPTH];
    int          held_count;
    bit          overflow_seen;
    bit          list_done;
    // Records still to arrive, oldest first.
    out_t        pending_records [$];
    // Tallies for the summary.
    int          requests;
    int          lists;
    int          settings;
    int          failures;
    int          overflow_records;
    int          kind_seen [4];

    function new();
      little_endian = 1'b0;
      eye_seg       = EYE_SEGMENT_RST;
      mouth_seg     = MOUTH_SEGMENT_RST;
      clear_list();
    endfunction

    function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_LITTLE_ENDIAN: little_endian = val[0];
        CFG_EYE_SEGMENT:   eye_seg = val;
        CFG_MOUTH_SEGMENT: mouth_seg = val;
        default: ;
      endcase
    endfunction

    // Byte swap of each 32-bit half; it converts in both directions.
    function logic [63:0] order_bytes(logic [63:0] w);
      if (!little_endian) return w;
      return {w[39:32], w[47:40], w[55:48], w[63:56],
              w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function void clear_list();
      await_hash    = 1'b0;
      img_bits      = '0;
      staged_ok     = 1'b0;
      staged_pal    = '0;
      active_ok     = 1'b0;
      active_pal    = '0;
      held_count    = 0;
      overflow_seen = 1'b0;
      list_done     = 1'b0;
    endfunction

    function bit wide_opcode(logic [7:0] op);
      case (op)
        OP_TIMG_HASH, OP_WIDE_31, OP_WIDE_32, OP_WIDE_33,
        OP_WIDE_35, OP_WIDE_36, OP_WIDE_42: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // A full held list drops the texture and marks the list as overflowed.
    function void hold_texture(bit seg, logic [63:0] key);
      if (held_count >= HELD_DEPTH) begin
        overflow_seen = 1'b1;
      end else begin
        held_seg[held_count] = seg;
        held_key[held_count] = key;
        held_count++;
      end
    endfunction

    function void push_record(logic [1:0] kind, logic [63:0] key, logic [63:0] pal);
      out_t rec;
      rec.record_kind  = kind;
      rec.key          = key;
      rec.palette_hash = pal;
      rec.overflow     = overflow_seen;
      rec.run_last     = 1'b0;
      pending_records.insert(pending_records.size(), rec);
    endfunction

    // Without a confirmed palette the held textures are simply discarded.
    function void flush_held();
      if (active_ok) begin
        for (int i = 0; i < held_count; i++)
          push_record(held_seg[i] ? KIND_SEG : KIND_HASH, held_key[i], active_pal);
      end
      held_count = 0;
    endfunction

    // Works out the records caused by one accepted request.
    function void note_request(in_t req);
      logic [63:0] word;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [7:0]  op;
      logic [2:0]  fmt;
      int          n_prior;
      out_t        tail;
      n_prior = pending_records.size();
      word = order_bytes(req.cmd_dword);
      w0 = word[63:32];
      w1 = word[31:0];
      op = w0[31:24];
      fmt = w0[23:21];
      requests++;

      if (!list_done) begin
        if (await_hash) begin
          // Second word of a wide command: the texture hash.
          await_hash = 1'b0;
          if (img_bits[5]) begin
            if (img_bits[2:0] == FMT_RGBA && img_bits[4:3] == SIZ_16B) begin
              staged_pal = word;
              staged_ok  = 1'b1;
            end else if (img_bits[2:0] == FMT_CI) begin
              hold_texture(1'b0, word);
            end
          end
        end else if (wide_opcode(op)) begin
          await_hash = 1'b1;
          img_bits = (op == OP_TIMG_HASH) ? {1'b1, w0[20:19], fmt} : 6'd0;
        end else begin
          case (op)
            OP_TIMG_PLAIN: begin
              if (fmt == FMT_CI && (w1[31:24] == eye_seg || w1[31:24] == mouth_seg))
                hold_texture(1'b1, {32'd0, w1[31:24], 24'd0});
            end
            OP_LOAD_PAL: begin
              if (staged_ok) begin
                active_pal = staged_pal;
                active_ok  = 1'b1;
                staged_ok  = 1'b0;
                push_record(KIND_PAL, active_pal, active_pal);
              end
            end
            OP_TRI1, OP_TRI2, OP_QUAD: flush_held();
            OP_END: begin
              flush_held();
              list_done = 1'b1;
            end
            default: ;
          endcase
        end
      end

      if (req.last) begin
        flush_held();
        push_record(KIND_END, '0, '0);
        clear_list();
        lists++;
      end

      // The final record of this request carries the run marker.
      if (pending_records.size() > n_prior) begin
        tail = pending_records.pop_back();
        tail.run_last = 1'b1;
        pending_records.insert(pending_records.size(), tail);
      end
    endfunction

    function void check_record(out_t got);
      out_t want;
      if (pending_records.size() == 0) begin
        $error("unexpected record: kind %0d key %h", got.record_kind, got.key);
        failures++;
        return;
      end
      want = pending_records.pop_front();
      kind_seen[want.record_kind]++;
      if (want.overflow) overflow_records++;
      if (got.record_kind !== want.record_kind) begin
        $error("record_kind mismatch: expected %0d, got %0d", want.record_kind,
               got.record_kind);
        failures++;
      end
      if (got.key !== want.key) begin
        $error("key mismatch: expected %h, got %h", want.key, got.key);
        failures++;
      end
      if (got.palette_hash !== want.palette_hash) begin
        $error("palette_hash mismatch: expected %h, got %h", want.palette_hash,
               got.palette_hash);
        failures++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow mismatch: expected %0d, got %0d", want.overflow, got.overflow);
        failures++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last mismatch: expected %0d, got %0d", want.run_last, got.run_last);
        failures++;
      end
    endfunction

    function int pending();
      return pending_records.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  binding_scoreboard sb;
  bit                calm;        // no idling on either side while set
  int                gap_ahead;   // idle cycles before the next request
  logic [63:0]       list_words [$];

  display_list_palette_binder_core #(
    .HELD_DEPTH(HELD_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int random_gap();
    if ($urandom_range(0, 99) < 75) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Appends one word to the list being built.
  function automatic void add_word(logic [63:0] w);
    list_words.insert(list_words.size(), w);
  endfunction

  // Command word builders, in the binder's logical byte order.
  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] cmd_word(logic [7:0] op);
    return {op, 24'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [63:0] image_word(logic [2:0] fmt, logic [1:0] siz);
    return {OP_TIMG_HASH, fmt, siz, 19'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [63:0] plain_word(logic [2:0] fmt, logic [7:0] seg);
    return {OP_TIMG_PLAIN, fmt, 21'($urandom), seg, 24'($urandom)};
  endfunction

  function automatic logic [7:0] draw_op();
    case ($urandom_range(0, 2))
      0: return OP_TRI1;
      1: return OP_TRI2;
      default: return OP_QUAD;
    endcase
  endfunction

  function automatic logic [7:0] other_wide_op();
    case ($urandom_range(0, 5))
      0: return OP_WIDE_31;
      1: return OP_WIDE_32;
      2: return OP_WIDE_33;
      3: return OP_WIDE_35;
      4: return OP_WIDE_36;
      default: return OP_WIDE_42;
    endcase
  endfunction

  // Record side: check each accepted record, then stall at random.
  initial begin
    int hold_off;
    hold_off = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_record(out_data);
      if (calm) begin
        out_ready <= 1'b1;
      end else if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 20) begin
        hold_off = random_gap() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one request and waits for it to be taken.
  task automatic send_word(logic [63:0] word, bit last);
    in_t req;
    req.cmd_dword = sb.order_bytes(word);
    req.last = last;
    repeat (gap_ahead) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
    gap_ahead = (calm || $urandom_range(0, 99) < 60) ? 0 : random_gap();
    if (gap_ahead > 0) in_valid <= 1'b0;
  endtask

  task automatic send_list();
    foreach (list_words[i]) send_word(list_words[i], i == list_words.size() - 1);
    list_words.delete();
  endtask

  // Withdraw valid before any pause in the request stream.
  task automatic stop_sending();
    if (gap_ahead == 0) in_valid <= 1'b0;
    gap_ahead = 0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic apply_settings(bit le, logic [7:0] eye, logic [7:0] mouth);
    stop_sending();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_LITTLE_ENDIAN;
    cfg_wdata <= {7'd0, le};
    @(posedge clk);
    sb.set_config(CFG_LITTLE_ENDIAN, {7'd0, le});
    cfg_idx   <= CFG_EYE_SEGMENT;
    cfg_wdata <= eye;
    @(posedge clk);
    sb.set_config(CFG_EYE_SEGMENT, eye);
    cfg_idx   <= CFG_MOUTH_SEGMENT;
    cfg_wdata <= mouth;
    @(posedge clk);
    sb.set_config(CFG_MOUTH_SEGMENT, mouth);
    cfg_we    <= 1'b0;
    sb.settings++;
  endtask

  // One colour-index texture, named by hash or by a segment pointer.
  task automatic push_texture();
    logic [7:0] seg;
    if ($urandom_range(0, 1) == 0) begin
      add_word(image_word(FMT_CI, 2'($urandom)));
      add_word(rand_word());
    end else begin
      case ($urandom_range(0, 3))
        0: seg = sb.mouth_seg;
        1: seg = 8'($urandom);
        default: seg = sb.eye_seg;
      endcase
      add_word(plain_word(($urandom_range(0, 99) < 85) ? FMT_CI : 3'($urandom), seg));
    end
  endtask

  // Builds a mostly well-formed list with random content and some noise.
  task automatic build_random_list(bit deep);
    int len;
    int pick;
    if ($urandom_range(0, 9) < 7) begin
      add_word(image_word(FMT_RGBA, SIZ_16B));
      add_word(rand_word());
      add_word(cmd_word(OP_LOAD_PAL));
    end
    // Overrun the held list so that the overflow flag can be reached.
    if (deep) repeat ($urandom_range(HELD_DEPTH + 1, HELD_DEPTH + 4)) push_texture();
    len = list_words.size() + (deep ? $urandom_range(1, 6) : $urandom_range(3, 20));
    while (list_words.size() < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        add_word(image_word(FMT_RGBA, SIZ_16B));
        add_word(rand_word());
      end else if (pick < 24) begin
        add_word(cmd_word(OP_LOAD_PAL));
      end else if (pick < 56) begin
        push_texture();
      end else if (pick < 70) begin
        add_word(cmd_word(draw_op()));
      end else if (pick < 76) begin
        add_word(cmd_word(other_wide_op()));
        add_word(rand_word());
      end else if (pick < 81) begin
        add_word(image_word(3'($urandom), 2'($urandom)));
        add_word(rand_word());
      end else if (pick < 88) begin
        add_word(rand_word());
      end else if (pick < 91) begin
        add_word(cmd_word(OP_END));
      end else begin
        repeat ($urandom_range(3, 12)) push_texture();
      end
    end
    // Cutting the tail can leave a wide opcode on the last word.
    while (list_words.size() > len) void'(list_words.pop_back());
  endtask

  task automatic random_phase(int goal);
    int first;
    int n;
    first = sb.requests;
    n = 0;
    while (sb.requests - first < goal) begin
      calm = ($urandom_range(0, 3) == 0);
      build_random_list(n == 0 || $urandom_range(0, 5) == 0);
      send_list();
      // Let the record stream run dry now and then.
      if (n % 3 == 0) begin
        stop_sending();
        wait_results();
      end
      n++;
    end
    calm = 1'b0;
  endtask

  initial begin
    sb = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    calm      = 1'b0;
    gap_ahead = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    apply_settings(1'b0, EYE_SEGMENT_RST, MOUTH_SEGMENT_RST);

    // Palette confirmed once, a second load without a staged palette, both
    // ways of naming a texture, ignored formats and segments, a foreign wide
    // opcode swallowing a draw, then words after the end command.
    add_word(image_word(FMT_RGBA, SIZ_16B));
    add_word(64'hFFFF_FFFF_FFFF_FFFF);
    add_word(cmd_word(OP_LOAD_PAL));
    add_word(cmd_word(OP_LOAD_PAL));
    add_word(image_word(FMT_CI, 2'($urandom)));
    add_word(64'h0);
    add_word(plain_word(FMT_CI, EYE_SEGMENT_RST));
    add_word(plain_word(FMT_CI, MOUTH_SEGMENT_RST));
    add_word(plain_word(FMT_CI, 8'hFF));
    add_word(plain_word(FMT_RGBA, EYE_SEGMENT_RST));
    add_word(cmd_word(OP_WIDE_31));
    add_word(cmd_word(OP_TRI1));
    add_word(cmd_word(OP_TRI1));
    add_word(cmd_word(OP_END));
    add_word(cmd_word(OP_TRI2));
    add_word(cmd_word(OP_QUAD));
    send_list();

    // No palette at the draw, and a wide opcode as the last word.
    add_word(image_word(FMT_CI, 2'($urandom)));
    add_word(rand_word());
    add_word(cmd_word(OP_QUAD));
    add_word(cmd_word(OP_WIDE_42));
    send_list();

    // A texture named by the last word itself, flushed with the end record.
    add_word(image_word(FMT_RGBA, SIZ_16B));
    add_word(rand_word());
    add_word(cmd_word(OP_LOAD_PAL));
    add_word(plain_word(FMT_CI, MOUTH_SEGMENT_RST));
    send_list();

    random_phase(40);
    apply_settings(1'b1, 8'h00, 8'hFF);
    random_phase(40);
    apply_settings(1'b0, 8'hFF, 8'h00);
    random_phase(40);
    begin
      logic [7:0] shared_seg;
      shared_seg = 8'($urandom);
      apply_settings(1'b1, shared_seg, shared_seg);
    end
    random_phase(40);
    apply_settings(1'($urandom), 8'($urandom), 8'($urandom));
    random_phase(40);

    stop_sending();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display(
      "Checked %0d records: %0d palette, %0d hash, %0d segment, %0d end, %0d overflowed.",
      sb.kind_seen[0] + sb.kind_seen[1] + sb.kind_seen[2] + sb.kind_seen[3],
      sb.kind_seen[KIND_PAL], sb.kind_seen[KIND_HASH], sb.kind_seen[KIND_SEG],
      sb.kind_seen[KIND_END], sb.overflow_records);
    $display("They came from %0d requests in %0d lists under %0d register settings.",
             sb.requests, sb.lists, sb.settings);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
